@@ hdl/crcec_pkg.sv @@
// ----------------------------------------------------------------------------
// crcec_pkg
// shared types, constants and the crc xor-network masks for the error checker
// ----------------------------------------------------------------------------
package crcec_pkg;

    localparam int DATA_W = 64;
    localparam int CRC_W  = 16;
    localparam int VEC_W  = DATA_W + CRC_W;

    // feedback taps without the leading term
    localparam logic [7:0]       POLY8  = 8'hCF;
    localparam logic [CRC_W-1:0] POLY16 = 16'h5935;

    typedef enum logic [0:0] {
        REG_CRC_MODE = 1'b0,
        REG_FIX_EN   = 1'b1
    } crcec_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CORRECTED = 2'd1,
        STATUS_DETECTED  = 2'd2
    } crcec_status_t;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] data_word;
        logic [CRC_W-1:0]  check_in;
        logic              last_word;
    } crcec_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] check_out;
        crcec_status_t    status;
    } crcec_result_t;

    // one row per crc output bit, one column per bit of {data_word, crc}
    typedef logic [CRC_W-1:0][VEC_W-1:0] crcec_mask_t;

    // bit-serial crc over one word, bit 0 first; only evaluated at elaboration
    function automatic logic [CRC_W-1:0] crc_shift(logic [CRC_W-1:0] crc_in,
                                                   logic [DATA_W-1:0] word,
                                                   logic wide);
        logic [CRC_W-1:0] c;
        logic             inv;
        c = wide ? crc_in : {8'h00, crc_in[7:0]};
        for (int i = 0; i < DATA_W; i++) begin
            inv = word[i] ^ (wide ? c[CRC_W-1] : c[7]);
            if (wide) begin
                c = {c[CRC_W-2:0], 1'b0} ^ (inv ? POLY16 : '0);
            end else begin
                c = {8'h00, c[6:0], 1'b0} ^ (inv ? {8'h00, POLY8} : '0);
            end
        end
        return c;
    endfunction

    // the shift is linear, so each output bit is the parity of a fixed subset
    function automatic crcec_mask_t build_masks(logic wide);
        crcec_mask_t      m;
        logic [VEC_W-1:0] v;
        logic [CRC_W-1:0] r;
        m = '0;
        for (int j = 0; j < VEC_W; j++) begin
            v    = '0;
            v[j] = 1'b1;
            r    = crc_shift(v[CRC_W-1:0], v[VEC_W-1:CRC_W], wide);
            for (int k = 0; k < CRC_W; k++) begin
                m[k][j] = r[k];
            end
        end
        return m;
    endfunction

    localparam crcec_mask_t MASK8  = build_masks(1'b0);
    localparam crcec_mask_t MASK16 = build_masks(1'b1);

endpackage

@@ hdl/crcec_in_reg.sv @@
// ----------------------------------------------------------------------------
// crcec_in_reg
// input register stage holding one item until the core consumes it
// ----------------------------------------------------------------------------
module crcec_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  crcec_pkg::crcec_item_t in_item,
    input  logic                 drain,
    output logic                 hold_valid,
    output crcec_pkg::crcec_item_t hold_item
);
    import crcec_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    crcec_item_t item_reg;

    assign in_ready   = !valid_reg || drain;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !drain);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

@@ hdl/crcec_core.sv @@
// ----------------------------------------------------------------------------
// crcec_core
// running crc and weight state, word xor network and end-of-block decision
// ----------------------------------------------------------------------------
module crcec_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  crcec_pkg::crcec_item_t item,
    input  logic                   crc_mode,
    input  logic                   fix_en,
    output crcec_pkg::crcec_result_t result
);
    import crcec_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [1:0]       ones_reg;
    logic [1:0]       ones_next;

    logic [CRC_W-1:0] crc_cur;
    logic [VEC_W-1:0] vec;
    crcec_mask_t      mask;
    logic [CRC_W-1:0] crc_new;
    logic             w_any;
    logic             w_multi;
    logic [1:0]       ones_new;
    logic [CRC_W-1:0] chk;
    logic             c_any;
    logic             c_multi;
    logic [1:0]       weight;
    crcec_status_t    status;

    // saturating weight add, capped at two
    function automatic logic [1:0] sat_add(logic [1:0] a, logic any, logic multi);
        logic [1:0] r;
        if (multi || a == 2'd2) begin
            r = 2'd2;
        end else if (any) begin
            r = a + 2'd1;
        end else begin
            r = a;
        end
        return r;
    endfunction

    assign crc_cur = crc_mode ? crc_reg : {8'h00, crc_reg[7:0]};
    assign vec     = {item.data_word, crc_cur};
    assign mask    = crc_mode ? MASK16 : MASK8;

    always_comb begin
        for (int k = 0; k < CRC_W; k++) begin
            crc_new[k] = ^(mask[k] & vec);
        end
    end

    assign w_any    = |item.data_word;
    assign w_multi  = |(item.data_word & (item.data_word - {{(DATA_W-1){1'b0}}, 1'b1}));
    assign ones_new = sat_add(ones_reg, w_any, w_multi);

    assign chk     = crc_mode ? item.check_in : {8'h00, item.check_in[7:0]};
    assign c_any   = |chk;
    assign c_multi = |(chk & (chk - {{(CRC_W-1){1'b0}}, 1'b1}));
    assign weight  = sat_add(ones_new, c_any, c_multi);

    always_comb begin
        if (!item.func) begin
            status = STATUS_OK;
        end else if (weight == 2'd1) begin
            status = fix_en ? STATUS_CORRECTED : STATUS_DETECTED;
        end else if ((crc_new ^ chk) == '0) begin
            status = STATUS_OK;
        end else begin
            status = STATUS_DETECTED;
        end
    end

    assign result.check_out = crc_new;
    assign result.status    = status;

    always_comb begin
        crc_next  = crc_reg;
        ones_next = ones_reg;
        if (take) begin
            crc_next  = item.last_word ? '0 : crc_new;
            ones_next = item.last_word ? 2'd0 : ones_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= '0;
            ones_reg <= 2'd0;
        end else begin
            crc_reg  <= crc_next;
            ones_reg <= ones_next;
        end
    end

endmodule

@@ hdl/crc8_crc16_error_check.sv @@
// ----------------------------------------------------------------------------
// crc8_crc16_error_check
// m_tvalid rises once a last item has passed the input and result registers
// throughput: one item per cycle, held while a last item waits on a full result
//   register; the 80-input xor network per crc bit sets the cycle, one word
//   fully folded into the crc register each cycle
// reset: synchronous active-low aresetn clears crc, weight, config, valids
// ----------------------------------------------------------------------------
module crc8_crc16_error_check (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [63:0] data_word, [79:64] check_in
    input  logic        s_tlast,   // last_word
    input  logic        s_tuser,   // func
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] check_out, [17:16] status, rest zero
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic        cfg_wr_data
);
    import crcec_pkg::*;

    crcec_item_t   in_item;
    crcec_item_t   hold_item;
    logic          hold_valid;
    logic          out_free;
    logic          take;
    logic          emit;
    crcec_result_t core_result;

    logic          crc_mode_reg;
    logic          crc_mode_next;
    logic          fix_en_reg;
    logic          fix_en_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    crcec_result_t m_result_reg;

    // configuration registers: the user writes them only while idle, the block does not enforce this
    always_comb begin
        crc_mode_next = crc_mode_reg;
        fix_en_next   = fix_en_reg;
        if (cfg_wr_en) begin
            case (crcec_reg_t'(cfg_addr))
                REG_CRC_MODE: crc_mode_next = cfg_wr_data;
                REG_FIX_EN:   fix_en_next   = cfg_wr_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_mode_reg <= 1'b0;
            fix_en_reg   <= 1'b0;
        end else begin
            crc_mode_reg <= crc_mode_next;
            fix_en_reg   <= fix_en_next;
        end
    end

    // unpack the stream payload into an item
    assign in_item.func      = s_tuser;
    assign in_item.data_word = s_tdata[DATA_W-1:0];
    assign in_item.check_in  = s_tdata[VEC_W-1:DATA_W];
    assign in_item.last_word = s_tlast;

    // a non-last item only updates state, so it always moves on;
    // a last item needs the output register to be free
    assign out_free = !m_valid_reg || m_tready;
    assign take     = hold_valid && (!hold_item.last_word || out_free);
    assign emit     = take && hold_item.last_word;

    crcec_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .drain      (take),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    crcec_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .item     (hold_item),
        .crc_mode (crc_mode_reg),
        .fix_en   (fix_en_reg),
        .result   (core_result)
    );

    // output register, parts the result side from the input side
    assign m_valid_next = emit || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_result_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_result_reg.status, m_result_reg.check_out};

endmodule

@@ hdl/crcec_checker.sv @@
// ----------------------------------------------------------------------------
// crcec_checker
// port-level assertions for the error checker, bound to the top level
// ----------------------------------------------------------------------------
module crcec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a fresh result follows a last item accepted before it, via the input and result registers
    a_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a last item");

    // status code is never the unused value, padding is zero
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:16] != 2'd3 && m_tdata[23:18] == 6'd0)
        else $error("bad status or padding");

endmodule

bind crc8_crc16_error_check crcec_checker u_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for crc8_crc16_error_check: a directed table of blocks
// and register writes, then random blocks of encode and check traffic, all
// scored against typed results or an in-bench crc and weight model, with random
// stalls on both streams and one long result back-pressure stretch
// ----------------------------------------------------------------------------
module testbench;
    import crcec_pkg::*;

    localparam int          SETTLE_CYCLES = 6;     // room for the result path plus margin
    localparam int          HOLD_CYCLES   = 200;   // long result stall for back-pressure
    localparam int          ITEM_TARGET   = 650;
    localparam int          PLAN_N        = 27;
    localparam logic [7:0]  TAPS8         = 8'hCF;
    localparam logic [15:0] TAPS16        = 16'h5935;
    localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES      = '1;

    typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_t;

    // shapes of a random block
    typedef enum logic [2:0] {
        BLK_ENCODE,     // encode, random data
        BLK_SPARSE,     // check, at most one set bit over data and check bits
        BLK_CODEWORD,   // check, check bits match the crc
        BLK_FLIPPED,    // check, crc with one check bit flipped
        BLK_NOISE       // check, random check bits
    } block_flavor_t;

    typedef struct packed {
        step_kind_t    kind;
        crcec_reg_t    reg_idx;
        logic          reg_val;
        logic          func;
        logic [63:0]   word;
        logic [15:0]   chk;
        logic          last;
        logic          known;       // expected result typed in below
        logic [15:0]   exp_crc;
        crcec_status_t exp_status;
    } plan_row_t;

    // directed part; rows with known = 0 are scored by the model alone
    localparam plan_row_t PLAN [0:PLAN_N-1] = '{
        // after reset: 8-bit mode, fix disabled
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, 64'h0,     16'h0000, 1'b1, 1'b1, 16'h0000, STATUS_OK},
        // a single bit entering last leaves exactly the taps
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, TOP_BIT,   16'h0000, 1'b1, 1'b1, 16'h00CF, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'h0000, 1'b1, 1'b1, 16'h0000, STATUS_OK},
        // weight one without fix is detected
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, TOP_BIT,   16'h0000, 1'b1, 1'b1, 16'h00CF,
          STATUS_DETECTED},
        // upper check byte ignored in 8-bit mode
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'hFF00, 1'b1, 1'b1, 16'h0000, STATUS_OK},
        // matching check bits, weight saturated
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, TOP_BIT,   16'h00CF, 1'b1, 1'b1, 16'h00CF, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, ALL_ONES,  16'hFFFF, 1'b1, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, ALL_ONES,  16'hFFFF, 1'b1, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_WRITE, REG_FIX_EN,   1'b1, 1'b0, 64'h0,     16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        // single bit in the check field, corrected
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'h0080, 1'b1, 1'b1, 16'h0000,
          STATUS_CORRECTED},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, TOP_BIT,   16'h0000, 1'b1, 1'b1, 16'h00CF,
          STATUS_CORRECTED},
        '{STEP_WRITE, REG_CRC_MODE, 1'b1, 1'b0, 64'h0,     16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, TOP_BIT,   16'h0000, 1'b1, 1'b1, 16'h5935, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'h8000, 1'b1, 1'b1, 16'h0000,
          STATUS_CORRECTED},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, TOP_BIT,   16'h5935, 1'b1, 1'b1, 16'h5935, STATUS_OK},
        // multi-word block; func and check bits on inner words do not matter
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF, 16'hFFFF, 1'b0, 1'b0,
          16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, 64'hFEDC_BA98_7654_3210, 16'h0000, 1'b1, 1'b0,
          16'h0000, STATUS_OK},
        // 16-bit to 8-bit switch inside a block drops the upper byte
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, ALL_ONES,  16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_WRITE, REG_CRC_MODE, 1'b0, 1'b0, 64'h0,     16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h8000_0000_0000_0001, 16'h1234, 1'b1, 1'b0,
          16'h0000, STATUS_OK},
        // 8-bit to 16-bit switch inside a block
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b0, 64'h5A5A_5A5A_A5A5_A5A5, 16'h0000, 1'b0, 1'b0,
          16'h0000, STATUS_OK},
        '{STEP_WRITE, REG_CRC_MODE, 1'b1, 1'b0, 64'h0,     16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'h0000, 1'b1, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_WRITE, REG_FIX_EN,   1'b0, 1'b0, 64'h0,     16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'h0001, 1'b1, 1'b1, 16'h0000,
          STATUS_DETECTED},
        // weight one spread over a two-word block
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h1,     16'h0000, 1'b0, 1'b0, 16'h0000, STATUS_OK},
        '{STEP_ITEM,  REG_CRC_MODE, 1'b0, 1'b1, 64'h0,     16'h0000, 1'b1, 1'b0, 16'h0000, STATUS_OK}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;    // [63:0] data_word, [79:64] check_in
    logic        s_tlast;    // last_word
    logic        s_tuser;    // func
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [15:0] check_out, [17:16] status, rest zero
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic        cfg_wr_data;

    // model state, kept in step with accepted items
    logic [15:0]   crc_acc;
    logic [1:0]    ones_acc;
    logic          mode_wide;
    logic          fix_en;

    crcec_result_t pending_results[$];
    crcec_result_t head;
    int            errors     = 0;
    int            items_sent = 0;
    logic          full_rate  = 1'b0;   // both sides run without gaps
    logic          hold_req   = 1'b0;   // asks the result side for one long stall

    crc8_crc16_error_check uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shift one word into the crc, bit 0 first, no reflection
    function automatic logic [15:0] advance_crc(input logic [15:0] crc, input logic [63:0] word,
                                                input logic wide);
        logic [15:0] r;
        logic        fb;
        r = wide ? crc : {8'h00, crc[7:0]};
        for (int i = 0; i < 64; i++) begin
            fb = word[i] ^ (wide ? r[15] : r[7]);
            r  = wide ? {r[14:0], 1'b0} : {8'h00, r[6:0], 1'b0};
            if (fb) begin
                r = r ^ (wide ? TAPS16 : {8'h00, TAPS8});
            end
        end
        return r;
    endfunction

    // set-bit count, saturating at two
    function automatic logic [1:0] add_ones(input logic [1:0] start, input logic [63:0] v);
        logic [1:0] n;
        n = start;
        for (int i = 0; i < 64; i++) begin
            if (v[i] && n < 2'd2) begin
                n = n + 2'd1;
            end
        end
        return n;
    endfunction

    // fold one accepted item into the model; a last word yields a result
    function automatic void fold_word(input crcec_item_t it, output logic produced,
                                      output crcec_result_t res);
        logic [15:0] chk;
        logic [1:0]  weight;
        crc_acc       = advance_crc(crc_acc, it.data_word, mode_wide);
        ones_acc      = add_ones(ones_acc, it.data_word);
        produced      = it.last_word;
        res.check_out = crc_acc;
        res.status    = STATUS_OK;
        if (it.last_word) begin
            if (it.func) begin
                chk    = mode_wide ? it.check_in : {8'h00, it.check_in[7:0]};
                weight = add_ones(ones_acc, {48'h0, chk});
                if (weight == 2'd1) begin
                    res.status = fix_en ? STATUS_CORRECTED : STATUS_DETECTED;
                end else if ((crc_acc ^ chk) != 16'h0000) begin
                    res.status = STATUS_DETECTED;
                end
            end
            crc_acc  = '0;
            ones_acc = '0;
        end
    endfunction

    // offer one item after a random gap, wait for the handshake, fold it into the model
    task automatic send_item(input crcec_item_t it, input logic known, input crcec_result_t typed);
        int            gap;
        logic          produced;
        crcec_result_t res;
        gap = full_rate ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.check_in, it.data_word};
        s_tlast  <= it.last_word;
        s_tuser  <= it.func;
        do @(posedge aclk); while (!s_tready);
        fold_word(it, produced, res);
        if (produced) begin
            pending_results.push_back(known ? typed : res);
        end
        items_sent++;
    endtask

    // drain all results, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input crcec_reg_t idx, input logic val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        if (idx == REG_CRC_MODE) begin
            mode_wide = val;
        end else begin
            fix_en = val;
        end
    endtask

    // one block of random words; with close = 0 the block stays open
    task automatic send_block(input block_flavor_t flavor, input int words, input logic close);
        crcec_item_t   it;
        crcec_result_t unused;
        int            target;
        logic [15:0]   good;
        unused = '0;
        // sparse blocks: one bit among data, check bits, or none at all
        target = $urandom_range(0, words * 64 + 23);
        for (int w = 0; w < words; w++) begin
            it.last_word = close && (w == words - 1);
            it.func      = it.last_word ? (flavor != BLK_ENCODE) : 1'($urandom_range(0, 1));
            it.check_in  = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       it.data_word = '0;
                1:       it.data_word = '1;
                2:       it.data_word = 64'h1 << $urandom_range(0, 63);
                default: it.data_word = {$urandom, $urandom};
            endcase
            if (flavor == BLK_SPARSE) begin
                it.data_word = '0;
                if (target / 64 == w) begin
                    it.data_word[target % 64] = 1'b1;
                end
            end
            if (it.last_word) begin
                good = advance_crc(crc_acc, it.data_word, mode_wide);
                case (flavor)
                    BLK_SPARSE: begin
                        it.check_in = (target >= words * 64 && target < words * 64 + 16) ?
                                      16'h1 << (target - words * 64) : 16'h0000;
                    end
                    BLK_CODEWORD: begin
                        it.check_in = good;
                        // junk in the unused upper byte
                        if (!mode_wide) begin
                            it.check_in[15:8] = 8'($urandom);
                        end
                    end
                    BLK_FLIPPED: begin
                        it.check_in = good ^ (16'h1 << $urandom_range(0, mode_wide ? 15 : 7));
                    end
                    default: ;
                endcase
            end
            send_item(it, 1'b0, unused);
        end
    endtask

    // result side: random ready gaps per item, one long hold on request
    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
            end else begin
                gap = full_rate ? 0 : $urandom_range(0, 6);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none expected, actual %h", $time, m_tdata);
                errors++;
            end else begin
                head = pending_results.pop_front();
                if (m_tdata[15:0] !== head.check_out) begin
                    $display("%0t: check_out mismatch, expected %h actual %h",
                             $time, head.check_out, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[17:16] !== head.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, head.status, m_tdata[17:16]);
                    errors++;
                end
                if (m_tdata[23:18] !== 6'h00) begin
                    $display("%0t: padding mismatch, expected %h actual %h",
                             $time, 6'h00, m_tdata[23:18]);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        crcec_item_t   it;
        crcec_result_t typed;
        block_flavor_t flavor;
        int            phase;
        int            blocks;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        s_tuser     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= 1'b0;
        cfg_wr_data <= 1'b0;
        crc_acc   = '0;
        ones_acc  = '0;
        mode_wide = 1'b0;
        fix_en    = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < PLAN_N; i++) begin
            if (PLAN[i].kind == STEP_WRITE) begin
                wait_idle();
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
            end else begin
                it.func         = PLAN[i].func;
                it.data_word    = PLAN[i].word;
                it.check_in     = PLAN[i].chk;
                it.last_word    = PLAN[i].last;
                typed.check_out = PLAN[i].exp_crc;
                typed.status    = PLAN[i].exp_status;
                send_item(it, PLAN[i].known, typed);
            end
        end

        // random phases, each under a fresh register setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            write_reg(REG_CRC_MODE, 1'($urandom_range(0, 1)));
            write_reg(REG_FIX_EN, 1'($urandom_range(0, 1)));
            full_rate = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // back-pressure: a long result stall while items are offered at full rate
                full_rate = 1'b1;
                hold_req  = 1'b1;
                repeat (40) send_block(BLK_CODEWORD, 1, 1'b1);
            end else begin
                blocks = $urandom_range(6, 16);
                repeat (blocks) begin
                    flavor = block_flavor_t'($urandom_range(0, 4));
                    send_block(flavor, ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) :
                                       $urandom_range(1, 3), 1'b1);
                end
                // sometimes leave a block open across the next register writes
                if ($urandom_range(0, 2) == 0) begin
                    send_block(BLK_NOISE, $urandom_range(1, 2), 1'b0);
                end
            end
            phase++;
        end

        wait_idle();
        if (errors == 0) begin
            $display("crc8_crc16_error_check regression: pass");
        end else begin
            $display("crc8_crc16_error_check regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("crc8_crc16_error_check regression: fail");
        $finish;
    end

endmodule
